// File: sv/lbfv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_pkg: shared types and constants of the four-vector Lorentz boost
// Fixed-point formats, register codes and the coefficient bundle.
// ----------------------------------------------------------------------------
package lbfv_pkg;

	localparam int CW = 32;      // coordinate width, Q16.16
	localparam int BW = 16;      // beta register width
	localparam int BF = 15;      // beta fraction bits
	localparam int GF = 32;      // gamma / k fraction bits
	localparam int GW = 48;      // gamma / k storage width (gamma <= 2^47)

	typedef logic [1:0]          cfg_idx_t;
	typedef logic [BW-1:0]       cfg_data_t;
	typedef logic signed [BW-1:0] beta_t;
	typedef logic signed [CW-1:0] coord_t;

	localparam cfg_idx_t CFG_BETA_X = 2'd0;
	localparam cfg_idx_t CFG_BETA_Y = 2'd1;
	localparam cfg_idx_t CFG_BETA_Z = 2'd2;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_SUMSQ,
		CS_SQRT,
		CS_DIVG,
		CS_DIVK
	} coef_state_t;

	typedef struct packed {
		logic [GW-1:0] gam;
		logic [GW-1:0] kfac;
		logic          bad;
		beta_t         bx;
		beta_t         by;
		beta_t         bz;
	} coef_t;

endpackage

// File: sv/lbfv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_if: stream channels of the four-vector boost
// Input four-vector channel and boosted result channel, valid/ready.
// ----------------------------------------------------------------------------
interface lbfv_in_if;
	import lbfv_pkg::*;
	logic   valid;
	logic   ready;
	coord_t time_coord;
	coord_t pos_x;
	coord_t pos_y;
	coord_t pos_z;
	modport source (output valid, time_coord, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, time_coord, pos_x, pos_y, pos_z, output ready);
endinterface

interface lbfv_out_if;
	import lbfv_pkg::*;
	logic   valid;
	logic   ready;
	coord_t boosted_time;
	coord_t boosted_x;
	coord_t boosted_y;
	coord_t boosted_z;
	logic   saturated;
	logic   bad_velocity;
	modport source (output valid, boosted_time, boosted_x, boosted_y, boosted_z,
		saturated, bad_velocity, input ready);
	modport sink (input valid, boosted_time, boosted_x, boosted_y, boosted_z,
		saturated, bad_velocity, output ready);
endinterface

// File: sv/lbfv_coef.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_coef: beta registers and gamma / k coefficient sequencer
// Sum of squares, bit-pair square root, then two restoring divisions.
// ----------------------------------------------------------------------------
module lbfv_coef (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  lbfv_pkg::cfg_idx_t  cfg_index,
	input  lbfv_pkg::cfg_data_t cfg_wdata,
	output lbfv_pkg::coef_t     coef,
	output logic                busy
);
	import lbfv_pkg::*;

	localparam logic [32:0] B2_ONE = 33'(1) << (2 * BF);

	beta_t       beta_q [3];
	coef_state_t state_q, state_d;
	logic [5:0]  cnt_q, cnt_d;
	logic [63:0] n_q, res_q, bit_q, rem_q, quo_q, div_q;
	logic [GW-1:0] gam_q, k_q;
	logic        bad_q;

	logic signed [31:0] sq [3];
	logic [32:0] b2;
	logic [32:0] d_w;
	logic [63:0] sq_sum, res_nx, n_nx, root;
	logic        sq_take;
	logic [64:0] remsh;
	logic        ge;
	logic [63:0] rem_nx, quo_nx, qk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q[0] <= '0;
			beta_q[1] <= '0;
			beta_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BETA_X: beta_q[0] <= beta_t'(cfg_wdata);
				CFG_BETA_Y: beta_q[1] <= beta_t'(cfg_wdata);
				CFG_BETA_Z: beta_q[2] <= beta_t'(cfg_wdata);
				default: ;
			endcase
		end
	end

	// arithmetic of one step
	always_comb begin
		for (int i = 0; i < 3; i++)
			sq[i] = 32'(beta_q[i]) * 32'(beta_q[i]);
		b2 = 33'($unsigned(sq[0])) + 33'($unsigned(sq[1])) + 33'($unsigned(sq[2]));
		d_w = B2_ONE - b2;
		sq_sum = res_q + bit_q;
		sq_take = n_q >= sq_sum;
		res_nx = sq_take ? (res_q >> 1) + bit_q : res_q >> 1;
		n_nx = sq_take ? n_q - sq_sum : n_q;
		root = (res_nx == '0) ? 64'd1 : res_nx;
		remsh = {rem_q, quo_q[63]};
		ge = remsh >= {1'b0, div_q};
		rem_nx = ge ? 64'(remsh - {1'b0, div_q}) : remsh[63:0];
		quo_nx = {quo_q[62:0], ge};
		qk = quo_nx + ((rem_nx == div_q - 64'd1) ? 64'd1 : 64'd0);
	end

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		case (state_q)
			CS_IDLE: ;
			CS_SUMSQ: state_d = (b2 >= B2_ONE) ? CS_IDLE : CS_SQRT;
			CS_SQRT: begin
				if (bit_q[0]) begin
					state_d = CS_DIVG;
					cnt_d = '1;
				end
			end
			CS_DIVG: begin
				cnt_d = cnt_q - 6'd1;
				if (cnt_q == '0) begin
					state_d = CS_DIVK;
					cnt_d = '1;
				end
			end
			CS_DIVK: begin
				cnt_d = cnt_q - 6'd1;
				if (cnt_q == '0)
					state_d = CS_IDLE;
			end
			default: state_d = CS_IDLE;
		endcase
		if (cfg_we)
			state_d = CS_SUMSQ;
	end

	always_comb begin
		busy = (state_q != CS_IDLE);
		coef.gam = gam_q;
		coef.kfac = k_q;
		coef.bad = bad_q;
		coef.bx = beta_q[0];
		coef.by = beta_q[1];
		coef.bz = beta_q[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_SUMSQ;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			CS_SUMSQ: begin
				bad_q <= (b2 >= B2_ONE);
				n_q <= {d_w[31:0], 32'd0};
				res_q <= '0;
				bit_q <= 64'(1) << 62;
			end
			CS_SQRT: begin
				n_q <= n_nx;
				res_q <= res_nx;
				bit_q <= bit_q >> 2;
				if (bit_q[0]) begin
					div_q <= root;
					quo_q <= (64'(1) << 63) + (root >> 1);
					rem_q <= '0;
				end
			end
			CS_DIVG: begin
				if (cnt_q == '0) begin
					gam_q <= quo_nx[GW-1:0];
					div_q <= quo_nx + (64'(1) << GF);
					quo_q <= '1;
					rem_q <= '0;
				end else begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
				end
			end
			CS_DIVK: begin
				rem_q <= rem_nx;
				quo_q <= quo_nx;
				if (cnt_q == '0)
					k_q <= gam_q - (GW'(1) << GF) + qk[GW-1:0];
			end
			default: ;
		endcase
	end

endmodule

// File: sv/lbfv_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbfv_pipe: fifteen-stage boost datapath
// Dot product, split gamma/k products, rounding, per-axis correction.
// ----------------------------------------------------------------------------
module lbfv_pipe (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_push,
	output logic            in_room,
	input  lbfv_pkg::coord_t time_coord,
	input  lbfv_pkg::coord_t pos_x,
	input  lbfv_pkg::coord_t pos_y,
	input  lbfv_pkg::coord_t pos_z,
	input  lbfv_pkg::coef_t  coef,
	output logic            out_valid,
	input  logic            out_ready,
	output lbfv_pkg::coord_t res_time,
	output lbfv_pkg::coord_t res_x,
	output lbfv_pkg::coord_t res_y,
	output lbfv_pkg::coord_t res_z,
	output logic            res_sat
);
	import lbfv_pkg::*;

	localparam int NS = 15;

	typedef struct packed {
		coord_t val;
		logic   clip;
	} clip_t;

	function automatic clip_t clip32(input logic signed [54:0] v);
		clip_t r;
		r.clip = 1'b0;
		r.val = coord_t'(v);
		if (v > 55'sd2147483647) begin
			r.val = 32'sh7fffffff;
			r.clip = 1'b1;
		end else if (v < -55'sd2147483648) begin
			r.val = 32'sh80000000;
			r.clip = 1'b1;
		end
		return r;
	endfunction

	logic [NS-1:0] vld_q;
	logic [NS-1:0] en;
	beta_t  beta [3];
	coord_t pos_in [3];

	// stage registers
	coord_t pos_s [1:NS][3];
	coord_t ct_s1, ct_s2;
	logic signed [47:0] p_s1 [3];
	logic signed [49:0] s_s2;
	logic [49:0] tm_s3, sm_s3;
	logic [31:0] ctm_s3;
	logic tneg_s3, tneg_s4, tneg_s5, tneg_s6, tneg_s7;
	logic sneg_s3, sneg_s4, sneg_s5, sneg_s6;
	logic ctneg_s3, ctneg_s4, ctneg_s5, ctneg_s6;
	logic [63:0] a_ll_s4, k_ll_s4, g_l_s4, a_ll_s5, k_ll_s5;
	logic [49:0] a_lh_s4, k_lh_s4;
	logic [47:0] a_hl_s4, k_hl_s4, g_h_s4;
	logic [33:0] a_hh_s4, k_hh_s4, a_hh_s5, k_hh_s5;
	logic [50:0] a_mid_s5, k_mid_s5;
	logic [79:0] g_s5, g_s6;
	logic [97:0] a_s6, k_s6;
	logic [50:0] tr_s7;
	logic signed [98:0] ks_s7;
	logic signed [80:0] gs_s7;
	logic signed [99:0] craw_s8;
	coord_t tim_s [8:NS];
	logic   tsat_s [8:NS-1];
	logic [98:0] cm_s9;
	logic cneg_s9, cneg_s10;
	logic [66:0] cmag_s10;
	logic [47:0] pp0_s11 [3], pp1_s11 [3];
	logic [18:0] pp2_s11 [3];
	logic pneg_s11 [3], pneg_s12 [3], pneg_s13 [3];
	logic [82:0] prod_s12 [3];
	logic [52:0] prm_s13 [3];
	logic signed [53:0] pr_s14 [3];
	coord_t out_s15 [3];
	logic   sat_s15;

	// combinational stage logic
	logic signed [47:0] p_w [3];
	logic signed [50:0] ct_w, t_w, t_abs;
	logic signed [49:0] s_abs;
	logic signed [32:0] ct_x, ct_n;
	logic [31:0] gl, kl;
	logic [15:0] gh, kh;
	logic [97:0] tr_sum;
	logic signed [98:0] k_pos;
	logic signed [80:0] g_pos;
	logic signed [51:0] t_pos, t_v;
	clip_t t_clip;
	logic signed [99:0] cm_w;
	logic [98:0] c_sum;
	logic signed [16:0] b_n [3];
	logic [15:0] bm [3];
	logic [82:0] pr_sum [3];
	logic signed [53:0] pr_pos [3];
	clip_t o_clip [3];

	assign beta[0] = coef.bx;
	assign beta[1] = coef.by;
	assign beta[2] = coef.bz;
	assign pos_in[0] = pos_x;
	assign pos_in[1] = pos_y;
	assign pos_in[2] = pos_z;
	assign gl = coef.gam[31:0];
	assign gh = coef.gam[GW-1:32];
	assign kl = coef.kfac[31:0];
	assign kh = coef.kfac[GW-1:32];

	// a stage moves on out_ready or when a stage from it to the output is empty
	always_comb begin
		logic full;
		for (int k = 0; k < NS; k++) begin
			full = 1'b1;
			for (int j = k; j < NS; j++)
				full = full & vld_q[j];
			en[k] = out_ready | ~full;
		end
	end

	assign in_room = en[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= in_push;
			for (int k = 1; k < NS; k++)
				if (en[k])
					vld_q[k] <= vld_q[k-1];
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			p_w[i] = 48'(pos_in[i]) * 48'(beta[i]);
			b_n[i] = -17'(beta[i]);
			bm[i] = beta[i][BW-1] ? b_n[i][15:0] : beta[i][15:0];
		end
		ct_w = 51'(ct_s2);
		t_w = (ct_w <<< BF) - 51'(s_s2);
		t_abs = t_w[50] ? -t_w : t_w;
		s_abs = s_s2[49] ? -s_s2 : s_s2;
		ct_x = 33'(ct_s2);
		ct_n = -ct_x;
		tr_sum = a_s6 + (98'(1) << (BF + GF - 1));
		k_pos = $signed({1'b0, k_s6});
		g_pos = $signed({1'b0, g_s6});
		t_pos = $signed({1'b0, tr_s7});
		t_v = tneg_s7 ? -t_pos : t_pos;
		t_clip = clip32(55'(t_v));
		cm_w = craw_s8[99] ? -craw_s8 : craw_s8;
		c_sum = cm_s9 + (99'(1) << (GF - 1));
		for (int i = 0; i < 3; i++) begin
			pr_sum[i] = prod_s12[i] + (83'(1) << (2 * BF - 1));
			pr_pos[i] = $signed({1'b0, prm_s13[i]});
			o_clip[i] = clip32(55'(pos_s[NS-1][i]) + 55'(pr_s14[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			ct_s1 <= time_coord;
			for (int i = 0; i < 3; i++) begin
				pos_s[1][i] <= pos_in[i];
				p_s1[i] <= p_w[i];
			end
		end
		for (int k = 2; k <= NS; k++)
			if (en[k-1])
				pos_s[k] <= pos_s[k-1];
		if (en[1]) begin
			ct_s2 <= ct_s1;
			s_s2 <= 50'(p_s1[0]) + 50'(p_s1[1]) + 50'(p_s1[2]);
		end
		if (en[2]) begin
			tneg_s3 <= t_w[50];
			tm_s3 <= t_abs[49:0];
			sneg_s3 <= s_s2[49];
			sm_s3 <= s_abs[49:0];
			ctneg_s3 <= ct_s2[CW-1];
			ctm_s3 <= ct_s2[CW-1] ? ct_n[31:0] : ct_x[31:0];
		end
		if (en[3]) begin
			a_ll_s4 <= 64'(gl) * 64'(tm_s3[31:0]);
			a_lh_s4 <= 50'(gl) * 50'(tm_s3[49:32]);
			a_hl_s4 <= 48'(gh) * 48'(tm_s3[31:0]);
			a_hh_s4 <= 34'(gh) * 34'(tm_s3[49:32]);
			k_ll_s4 <= 64'(kl) * 64'(sm_s3[31:0]);
			k_lh_s4 <= 50'(kl) * 50'(sm_s3[49:32]);
			k_hl_s4 <= 48'(kh) * 48'(sm_s3[31:0]);
			k_hh_s4 <= 34'(kh) * 34'(sm_s3[49:32]);
			g_l_s4 <= 64'(gl) * 64'(ctm_s3);
			g_h_s4 <= 48'(gh) * 48'(ctm_s3);
			tneg_s4 <= tneg_s3;
			sneg_s4 <= sneg_s3;
			ctneg_s4 <= ctneg_s3;
		end
		if (en[4]) begin
			a_ll_s5 <= a_ll_s4;
			a_hh_s5 <= a_hh_s4;
			a_mid_s5 <= 51'(a_lh_s4) + 51'(a_hl_s4);
			k_ll_s5 <= k_ll_s4;
			k_hh_s5 <= k_hh_s4;
			k_mid_s5 <= 51'(k_lh_s4) + 51'(k_hl_s4);
			g_s5 <= 80'(g_l_s4) + (80'(g_h_s4) << 32);
			tneg_s5 <= tneg_s4;
			sneg_s5 <= sneg_s4;
			ctneg_s5 <= ctneg_s4;
		end
		if (en[5]) begin
			a_s6 <= {a_hh_s5, a_ll_s5} + (98'(a_mid_s5) << 32);
			k_s6 <= {k_hh_s5, k_ll_s5} + (98'(k_mid_s5) << 32);
			g_s6 <= g_s5;
			tneg_s6 <= tneg_s5;
			sneg_s6 <= sneg_s5;
			ctneg_s6 <= ctneg_s5;
		end
		if (en[6]) begin
			tr_s7 <= tr_sum[97:47];
			tneg_s7 <= tneg_s6;
			ks_s7 <= sneg_s6 ? -k_pos : k_pos;
			gs_s7 <= ctneg_s6 ? -g_pos : g_pos;
		end
		if (en[7]) begin
			craw_s8 <= 100'(ks_s7) - (100'(gs_s7) <<< BF);
			tim_s[8] <= t_clip.val;
			tsat_s[8] <= t_clip.clip;
		end
		for (int k = 9; k <= NS; k++)
			if (en[k-1])
				tim_s[k] <= tim_s[k-1];
		for (int k = 9; k < NS; k++)
			if (en[k-1])
				tsat_s[k] <= tsat_s[k-1];
		if (en[8]) begin
			cneg_s9 <= craw_s8[99];
			cm_s9 <= cm_w[98:0];
		end
		if (en[9]) begin
			cneg_s10 <= cneg_s9;
			cmag_s10 <= c_sum[98:32];
		end
		for (int i = 0; i < 3; i++) begin
			if (en[10]) begin
				pp0_s11[i] <= 48'(cmag_s10[31:0]) * 48'(bm[i]);
				pp1_s11[i] <= 48'(cmag_s10[63:32]) * 48'(bm[i]);
				pp2_s11[i] <= 19'(cmag_s10[66:64]) * 19'(bm[i]);
				pneg_s11[i] <= cneg_s10 ^ beta[i][BW-1];
			end
			if (en[11]) begin
				prod_s12[i] <= {pp2_s11[i], 16'd0, pp0_s11[i]} + (83'(pp1_s11[i]) << 32);
				pneg_s12[i] <= pneg_s11[i];
			end
			if (en[12]) begin
				prm_s13[i] <= pr_sum[i][82:30];
				pneg_s13[i] <= pneg_s12[i];
			end
			if (en[13])
				pr_s14[i] <= pneg_s13[i] ? -pr_pos[i] : pr_pos[i];
			if (en[14])
				out_s15[i] <= o_clip[i].val;
		end
		if (en[14])
			sat_s15 <= tsat_s[14] | o_clip[0].clip | o_clip[1].clip | o_clip[2].clip;
	end

	assign res_time = tim_s[NS];
	assign res_x = out_s15[0];
	assign res_y = out_s15[1];
	assign res_z = out_s15[2];
	assign res_sat = sat_s15;

endmodule

// File: sv/lorentz_boost_four_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lorentz_boost_four_vector: general-direction Lorentz boost of (ct,x,y,z)
// Boosts each four-vector into the frame moving with the programmed beta.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  cfg       in   cfg_we             index 0..2 = beta_x/y/z, Q0.15
//  vec_in    in   valid/ready        ct, x, y, z  (Q16.16)
//  vec_out   out  valid/ready        ct', x', y', z', saturated, bad_velocity
//
//  One word per cycle unless busy or back-pressure holds the input.
//  After reset and after every beta write the coefficient sequencer runs
//  a sum of squares, the root steps, then the gamma and k divide steps;
//  vec_in.ready stays low while it runs. Beta with |beta| >= 1 ends it early.
//  Each stage advances when vec_out.ready is high or it or a later stage is
//  empty, so output stalls fill bubbles first; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module lorentz_boost_four_vector (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  lbfv_pkg::cfg_idx_t  cfg_index,
	input  lbfv_pkg::cfg_data_t cfg_wdata,
	lbfv_in_if.sink             vec_in,
	lbfv_out_if.source          vec_out
);
	import lbfv_pkg::*;

	coef_t  coef;
	logic   busy;
	logic   room;
	logic   push;
	coord_t r_time, r_x, r_y, r_z;
	logic   r_sat;

	// gamma, k and the beta registers; busy while recomputing
	lbfv_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.coef      (coef),
		.busy      (busy)
	);

	// input is held off while coefficients are not settled
	assign vec_in.ready = room & ~busy;
	assign push = vec_in.valid & vec_in.ready;

	lbfv_pipe u_pipe (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_push    (push),
		.in_room    (room),
		.time_coord (vec_in.time_coord),
		.pos_x      (vec_in.pos_x),
		.pos_y      (vec_in.pos_y),
		.pos_z      (vec_in.pos_z),
		.coef       (coef),
		.out_valid  (vec_out.valid),
		.out_ready  (vec_out.ready),
		.res_time   (r_time),
		.res_x      (r_x),
		.res_y      (r_y),
		.res_z      (r_z),
		.res_sat    (r_sat)
	);

	// superluminal beta: all components zero, no clip flag
	assign vec_out.boosted_time = coef.bad ? '0 : r_time;
	assign vec_out.boosted_x = coef.bad ? '0 : r_x;
	assign vec_out.boosted_y = coef.bad ? '0 : r_y;
	assign vec_out.boosted_z = coef.bad ? '0 : r_z;
	assign vec_out.saturated = r_sat & ~coef.bad;
	assign vec_out.bad_velocity = coef.bad;

	a_cfg_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (busy && !vec_in.ready))
		else $error("input accepted right after a beta write");

	a_no_push_busy: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !busy)
		else $error("word accepted during coefficient update");

	a_bad_no_sat: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid && vec_out.bad_velocity |-> !vec_out.saturated)
		else $error("saturated flagged with bad velocity");

endmodule

// File: verif/tb_lorentz_boost_four_vector.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lorentz_boost_four_vector: self-checking bench of the four-vector boost
// Programs several beta settings (zero, near-light extremes, too-fast beta,
// random), streams four-vectors with random gaps and output back-pressure, and
// checks every word against a typed result or a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_lorentz_boost_four_vector;
	import lbfv_pkg::*;

	typedef logic signed [127:0] wide_t;

	// one boosted word
	typedef struct {
		coord_t t;
		coord_t x;
		coord_t y;
		coord_t z;
		logic   sat;
		logic   bad;
	} boost_res_t;

	// one directed row: beta setting, input vector, optional typed result
	typedef struct {
		beta_t      bx;
		beta_t      by;
		beta_t      bz;
		coord_t     ct;
		coord_t     x;
		coord_t     y;
		coord_t     z;
		bit         typed;
		boost_res_t res;
	} vec_row_t;

	localparam coord_t CMAX = 32'sh7FFF_FFFF;
	localparam coord_t CMIN = 32'sh8000_0000;
	localparam beta_t  BMAX = 16'sd32767;

	logic clk;
	logic arst_n;
	logic cfg_we;
	cfg_idx_t  cfg_index;
	cfg_data_t cfg_wdata;

	lbfv_in_if  vin();
	lbfv_out_if vout();

	lorentz_boost_four_vector DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.vec_in    (vin),
		.vec_out   (vout)
	);

	// shadow of the beta registers, only changed while the block is idle
	beta_t beta_sh [3];

	boost_res_t boosts_due [$];
	vec_row_t   dir_rows [$];

	int  errors     = 0;
	int  words_in   = 0;
	int  words_out  = 0;
	int  sat_seen   = 0;
	int  bad_seen   = 0;
	int  settings   = 0;
	bit  no_gaps    = 0;
	// typed override for the word currently offered
	bit         use_typed = 0;
	boost_res_t typed_res;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// ---------------------------------------------------------------- predictor
	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res;
		logic [63:0] bit_w;
		res   = 0;
		bit_w = 64'd1 << 62;
		while (bit_w > n) bit_w = bit_w >> 2;
		while (bit_w != 0) begin
			if (n >= res + bit_w) begin
				n   = n - (res + bit_w);
				res = (res >> 1) + bit_w;
			end else begin
				res = res >> 1;
			end
			bit_w = bit_w >> 2;
		end
		return res;
	endfunction

	// round to nearest, ties away from zero, dropping sh fraction bits
	function automatic wide_t round_away(wide_t a, int sh);
		wide_t mag;
		mag = (a < 0) ? -a : a;
		mag = (mag + (wide_t'(1) <<< (sh - 1))) >>> sh;
		return (a < 0) ? -mag : mag;
	endfunction

	function automatic coord_t clip(wide_t v, ref logic sat);
		if (v > wide_t'(CMAX)) begin
			sat = 1'b1;
			return CMAX;
		end
		if (v < wide_t'(CMIN)) begin
			sat = 1'b1;
			return CMIN;
		end
		return coord_t'(v);
	endfunction

	function automatic boost_res_t boost_vector(coord_t ct, coord_t px, coord_t py,
		coord_t pz);
		boost_res_t  r;
		wide_t       b [3];
		wide_t       p [3];
		wide_t       b2, gam_w, k_w, s, c, ctw;
		logic [63:0] d, root, gam;
		logic        sat;
		r   = '{default: 0};
		sat = 1'b0;
		for (int i = 0; i < 3; i++) b[i] = beta_sh[i];
		b2 = b[0] * b[0] + b[1] * b[1] + b[2] * b[2];
		if (b2 >= (wide_t'(1) <<< (2 * BF))) begin
			r.bad = 1'b1;
			return r;
		end
		d    = 64'((wide_t'(1) <<< (2 * BF)) - b2);
		root = root_floor(d << (62 - 2 * BF));
		if (root == 0) root = 1;
		gam   = ((64'd1 << 63) + (root >> 1)) / root;
		gam_w = {64'd0, gam};
		// k = gamma^2/(gamma+1), exactly one half at beta = 0
		k_w = gam_w - (wide_t'(1) <<< GF) + ((wide_t'(1) <<< (2 * GF)) /
			(gam_w + (wide_t'(1) <<< GF)));
		ctw = ct;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		s = p[0] * b[0] + p[1] * b[1] + p[2] * b[2];
		r.t = clip(round_away(((ctw <<< BF) - s) * gam_w, BF + GF), sat);
		c = round_away(s * k_w - ((ctw * gam_w) <<< BF), GF);
		r.x = clip(p[0] + round_away(c * b[0], 2 * BF), sat);
		r.y = clip(p[1] + round_away(c * b[1], 2 * BF), sat);
		r.z = clip(p[2] + round_away(c * b[2], 2 * BF), sat);
		r.sat = sat;
		return r;
	endfunction

	// ---------------------------------------------------------------- monitors
	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endtask

	// inputs and outputs sampled at the rising edge, before the block updates
	always @(posedge clk) begin
		boost_res_t e;
		if (vin.valid && vin.ready) begin
			words_in++;
			if (use_typed)
				boosts_due.push_back(typed_res);
			else
				boosts_due.push_back(boost_vector(vin.time_coord, vin.pos_x,
					vin.pos_y, vin.pos_z));
		end
		if (vout.valid && vout.ready) begin
			words_out++;
			if (vout.saturated) sat_seen++;
			if (vout.bad_velocity) bad_seen++;
			if (boosts_due.size() == 0) begin
				$error("boosted word with nothing outstanding");
				errors++;
			end else begin
				e = boosts_due.pop_front();
				check_field("boosted_time", e.t, vout.boosted_time);
				check_field("boosted_x", e.x, vout.boosted_x);
				check_field("boosted_y", e.y, vout.boosted_y);
				check_field("boosted_z", e.z, vout.boosted_z);
				check_field("saturated", e.sat, vout.saturated);
				check_field("bad_velocity", e.bad, vout.bad_velocity);
			end
		end
	end

	// output back-pressure about 32% of the time, except in the no-gap stretch
	always @(negedge clk)
		vout.ready <= no_gaps || ($urandom_range(99) >= 32);

	// ---------------------------------------------------------------- drivers
	// drives one write for a cycle; the caller drops cfg_we afterwards
	task automatic write_beta(cfg_idx_t idx, beta_t val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx <= CFG_BETA_Z) beta_sh[idx] = val;
		@(negedge clk);
	endtask

	// drain everything, then cover the pipeline depth before touching beta
	task automatic wait_idle();
		while (boosts_due.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_beta(beta_t bx, beta_t by, beta_t bz);
		wait_idle();
		write_beta(CFG_BETA_X, bx);
		write_beta(CFG_BETA_Y, by);
		write_beta(CFG_BETA_Z, bz);
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic send_vec(coord_t ct, coord_t px, coord_t py, coord_t pz);
		int seen;
		while (!no_gaps && $urandom_range(99) < 32) begin
			vin.valid <= 1'b0;
			@(negedge clk);
		end
		vin.valid      <= 1'b1;
		vin.time_coord <= ct;
		vin.pos_x      <= px;
		vin.pos_y      <= py;
		vin.pos_z      <= pz;
		seen = words_in;
		do @(negedge clk); while (words_in == seen);
	endtask

	task automatic add_row(beta_t bx, beta_t by, beta_t bz, coord_t ct, coord_t px,
		coord_t py, coord_t pz, bit typed, boost_res_t res);
		dir_rows.push_back('{bx, by, bz, ct, px, py, pz, typed, res});
	endtask

	function automatic coord_t rand_coord();
		case ($urandom_range(4))
			0: return coord_t'($urandom);
			1: return coord_t'($urandom_range(32'h0020_0000)) - 32'sh0010_0000;
			2: return $urandom_range(1) ? CMAX : CMIN;
			3: return coord_t'($urandom_range(255)) - 128;
			default: return coord_t'($urandom) >>> $urandom_range(16);
		endcase
	endfunction

	function automatic beta_t rand_beta(int mode);
		case (mode)
			0: return beta_t'($urandom_range(65534)) - BMAX;
			1: return beta_t'($urandom_range(36000)) - 16'sd18000;
			default: return beta_t'($urandom_range(4000)) - 16'sd2000;
		endcase
	endfunction

	// ---------------------------------------------------------------- sequence
	initial begin
		boost_res_t zero_res;
		boost_res_t bad_res;
		vec_row_t   row;
		int         mode;
		vin.valid      = 1'b0;
		vin.time_coord = '0;
		vin.pos_x      = '0;
		vin.pos_y      = '0;
		vin.pos_z      = '0;
		vout.ready     = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = CFG_BETA_X;
		cfg_wdata      = '0;
		beta_sh        = '{default: 0};
		arst_n         = 1'b0;
		zero_res       = '{default: 0};
		bad_res        = '{default: 0};
		bad_res.bad    = 1'b1;

		// beta zero after reset: identity, including the coordinate extremes
		add_row(0, 0, 0, 0, 0, 0, 0, 1, zero_res);
		add_row(0, 0, 0, CMAX, CMAX, CMAX, CMAX, 1,
			'{CMAX, CMAX, CMAX, CMAX, 1'b0, 1'b0});
		add_row(0, 0, 0, CMIN, CMIN, CMIN, CMIN, 1,
			'{CMIN, CMIN, CMIN, CMIN, 1'b0, 1'b0});
		add_row(0, 0, 0, 32'sh0001_0000, -32'sh0002_8000, 32'sd1, -32'sd1, 1,
			'{32'sh0001_0000, -32'sh0002_8000, 32'sd1, -32'sd1, 1'b0, 1'b0});
		// near-light boosts along each axis: gamma about 128, heavy clipping
		add_row(BMAX, 0, 0, CMAX, 0, 0, 0, 0, zero_res);
		add_row(BMAX, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0, zero_res);
		add_row(BMAX, 0, 0, CMIN, CMAX, CMIN, CMAX, 0, zero_res);
		add_row(0, -BMAX, 0, 32'sh0000_1000, CMIN, CMAX, 0, 0, zero_res);
		add_row(0, -BMAX, 0, CMIN, CMIN, CMIN, CMIN, 0, zero_res);
		add_row(0, 0, BMAX, CMAX, CMAX, CMAX, CMAX, 0, zero_res);
		add_row(0, 0, BMAX, -32'sd1, 32'sd1, -32'sd1, 32'sd1, 0, zero_res);
		// too fast: outputs zero and the error flag
		add_row(BMAX, BMAX, 0, CMAX, CMAX, CMAX, CMAX, 1, bad_res);
		add_row(BMAX, BMAX, 0, 32'sd12345, -32'sd6789, 0, 32'sd5, 1, bad_res);
		// pattern 0x8000 is exactly -1, already too fast on its own
		add_row(16'sh8000, 0, 0, CMIN, 0, CMAX, 0, 1, bad_res);
		add_row(16'sh8000, 0, 0, 0, 0, 0, 0, 1, bad_res);
		// general direction, moderate speed, then one diagonal close to light speed
		add_row(16'sd16384, -16'sd8192, 16'sd4096, 32'sh0010_0000, 32'sh0003_0000,
			-32'sh0007_4000, 32'sh0000_8000, 0, zero_res);
		add_row(16'sd16384, -16'sd8192, 16'sd4096, CMAX, CMIN, CMAX, CMIN, 0, zero_res);
		add_row(16'sd16384, -16'sd8192, 16'sd4096, CMIN, CMAX, CMIN, CMAX, 0, zero_res);
		add_row(16'sd16384, -16'sd8192, 16'sd4096, -32'sd3, 32'sd7, -32'sd11, 32'sd13,
			0, zero_res);
		add_row(-16'sd18918, -16'sd18918, -16'sd18918, 32'sh0100_0000, 32'sh0010_0000,
			32'sh0010_0000, 32'sh0010_0000, 0, zero_res);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.bx != beta_sh[0] || row.by != beta_sh[1] || row.bz != beta_sh[2]) begin
				vin.valid <= 1'b0;
				use_typed = 0;
				set_beta(row.bx, row.by, row.bz);
			end
			use_typed = row.typed;
			typed_res = row.res;
			send_vec(row.ct, row.x, row.y, row.z);
		end
		vin.valid <= 1'b0;
		use_typed = 0;

		// the unused index 3 must leave all three registers alone
		wait_idle();
		write_beta(cfg_idx_t'(3), 16'sh7FFF);
		cfg_we <= 1'b0;
		send_vec(32'sh0004_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0000_4000);

		// random phases, each with its own beta; phase 4 has no gaps anywhere
		for (int ph = 0; ph < 10; ph++) begin
			vin.valid <= 1'b0;
			mode = $urandom_range(2);
			set_beta(rand_beta(mode), rand_beta(mode), rand_beta(mode));
			no_gaps = (ph == 4);
			for (int n = 0; n < 75; n++)
				send_vec(rand_coord(), rand_coord(), rand_coord(), rand_coord());
			no_gaps = 0;
		end
		vin.valid <= 1'b0;

		wait_idle();
		repeat (20) @(negedge clk);
		if (boosts_due.size() != 0) begin
			$error("%0d boosted words never arrived", boosts_due.size());
			errors++;
		end
		$display("Boosted %0d four-vectors under %0d beta settings", words_out, settings);
		$display("%0d words clipped, %0d flagged as too-fast beta", sat_seen, bad_seen);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#3ms;
		$display("Test completed with failures");
		$finish;
	end

endmodule
